/* rtl/tfc_pkg.sv */
package tfc_pkg;

	localparam int REG_BITS = 13;
	localparam int BOX_BITS = 29;
	localparam int DEF_COORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [REG_BITS-1:0] WIDTH_RESET = REG_BITS'(320);
	localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(240);

	typedef enum logic [1:0] {
		REG_WIDTH = 2'd0,
		REG_HEIGHT = 2'd1
	} reg_index_t;

	typedef enum logic [1:0] {
		CLS_REJECT = 2'd0,
		CLS_ACCEPT = 2'd1,
		CLS_CLIP = 2'd2
	} clip_class_t;

	typedef struct packed {
		logic take;
		logic full;
	} front_ctl_t;

endpackage

/* rtl/tfc_front.sv */
module tfc_front #(
	parameter int CB = tfc_pkg::DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tfc_pkg::front_ctl_t    ctl,
	input  logic signed [CB-1:0]   vx [3],
	input  logic signed [CB-1:0]   vy [3],
	input  logic signed [CB-1:0]   vz [3],
	input  logic signed [CB-1:0]   vw [3],
	output logic                   vld_s1,
	output tfc_pkg::clip_class_t   cls_s1,
	output logic [CB-1:0]          numx_s1 [3],
	output logic [CB-1:0]          numy_s1 [3],
	output logic [CB-1:0]          den_s1 [3]
);
	import tfc_pkg::*;

	logic [5:0] outside [3];
	logic [5:0] all_out;
	logic any_out;
	clip_class_t cls;
	logic signed [CB:0] xe, ye, ze, we, nwe;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xe = {vx[i][CB-1], vx[i]};
			ye = {vy[i][CB-1], vy[i]};
			ze = {vz[i][CB-1], vz[i]};
			we = {vw[i][CB-1], vw[i]};
			nwe = -we;
			outside[i][0] = xe < nwe;
			outside[i][1] = xe > we;
			outside[i][2] = ye < nwe;
			outside[i][3] = ye > we;
			outside[i][4] = ze[CB];
			outside[i][5] = ze > we;
		end
		all_out = outside[0] & outside[1] & outside[2];
		any_out = |(outside[0] | outside[1] | outside[2]);
		if (|all_out) begin
			cls = CLS_REJECT;
		end else if (any_out) begin
			cls = CLS_CLIP;
		end else begin
			cls = CLS_ACCEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ctl.take) begin
			vld_s1 <= 1'b1;
		end else if (!ctl.full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cls_s1 <= cls;
			for (int i = 0; i < 3; i++) begin
				numx_s1[i] <= CB'(vx[i] + vw[i]);
				numy_s1[i] <= CB'(vw[i] - vy[i]);
				den_s1[i] <= {vw[i][CB-2:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/tfc_fifo.sv */
module tfc_fifo #(
	parameter int DW = 8,
	parameter int DEPTH = tfc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	output logic          vld,
	output logic [DW-1:0] dout
);
	import tfc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign vld = (cnt_q != '0);
	assign dout = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

/* rtl/tfc_div.sv */
module tfc_div #(
	parameter int CB = tfc_pkg::DEF_COORD_BITS,
	parameter int FB = tfc_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic [tfc_pkg::REG_BITS+CB-1:0]  prod,
	input  logic [CB-1:0]                    den,
	output logic [tfc_pkg::REG_BITS+FB-1:0]  quo
);
	import tfc_pkg::*;

	localparam int QB = REG_BITS + FB;

	logic [CB-1:0] rem_s [QB];
	logic [QB-1:0] lo_s [QB];
	logic [QB-1:0] q_s [QB];
	logic [CB-1:0] d_s [QB];
	logic [CB-1:0] rem_n [QB];
	logic [QB-1:0] lo_n [QB];
	logic [QB-1:0] q_n [QB];
	logic [CB-1:0] d_n [QB];
	logic [CB-1:0] cr, cd;
	logic [QB-1:0] cl, cq;
	logic [CB:0] t;
	logic ge;

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				cr = prod[REG_BITS+CB-1:REG_BITS];
				cl = {prod[REG_BITS-1:0], {FB{1'b0}}};
				cq = '0;
				cd = den;
			end else begin
				cr = rem_s[k-1];
				cl = lo_s[k-1];
				cq = q_s[k-1];
				cd = d_s[k-1];
			end
			t = {cr, cl[QB-1]};
			ge = t >= {1'b0, cd};
			rem_n[k] = ge ? CB'(t - {1'b0, cd}) : CB'(t);
			lo_n[k] = {cl[QB-2:0], 1'b0};
			q_n[k] = {cq[QB-2:0], ge};
			d_n[k] = cd;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QB; k++) begin
			rem_s[k] <= rem_n[k];
			lo_s[k] <= lo_n[k];
			q_s[k] <= q_n[k];
			d_s[k] <= d_n[k];
		end
	end

	assign quo = (d_s[QB-1] == '0) ? '0 : q_s[QB-1];

endmodule

/* rtl/tfc_back.sv */
module tfc_back #(
	parameter int CB = tfc_pkg::DEF_COORD_BITS,
	parameter int FB = tfc_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  tfc_pkg::clip_class_t          cls,
	input  logic [CB-1:0]                 numx [3],
	input  logic [CB-1:0]                 numy [3],
	input  logic [CB-1:0]                 den [3],
	input  logic [tfc_pkg::REG_BITS-1:0]  scr_w,
	input  logic [tfc_pkg::REG_BITS-1:0]  scr_h,
	output logic                          done,
	output tfc_pkg::clip_class_t          out_cls,
	output logic [tfc_pkg::BOX_BITS-1:0]  min_x,
	output logic [tfc_pkg::BOX_BITS-1:0]  min_y,
	output logic [tfc_pkg::BOX_BITS-1:0]  max_x,
	output logic [tfc_pkg::BOX_BITS-1:0]  max_y
);
	import tfc_pkg::*;

	localparam int QB = REG_BITS + FB;
	localparam int PB = REG_BITS + CB;

	logic vld_s1;
	clip_class_t cls_s1;
	logic [PB-1:0] px_s1 [3];
	logic [PB-1:0] py_s1 [3];
	logic [CB-1:0] den_s1 [3];
	logic vld_d_q [QB];
	clip_class_t cls_d_q [QB];
	logic [QB-1:0] rx [3];
	logic [QB-1:0] ry [3];
	logic [QB-1:0] mnx, mxx, mny, mxy, limx, limy, fullx, fully;
	logic [REG_BITS-1:0] wm1, hm1;
	logic done_q;
	clip_class_t cls_q;
	logic [BOX_BITS-1:0] mnx_q, mny_q, mxx_q, mxy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k < QB; k++) begin
				vld_d_q[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_d_q[0] <= vld_s1;
			for (int k = 1; k < QB; k++) begin
				vld_d_q[k] <= vld_d_q[k-1];
			end
			done_q <= vld_d_q[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		cls_s1 <= cls;
		for (int i = 0; i < 3; i++) begin
			px_s1[i] <= PB'(scr_w) * PB'(numx[i]);
			py_s1[i] <= PB'(scr_h) * PB'(numy[i]);
			den_s1[i] <= den[i];
		end
		cls_d_q[0] <= cls_s1;
		for (int k = 1; k < QB; k++) begin
			cls_d_q[k] <= cls_d_q[k-1];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		tfc_div #(.CB(CB), .FB(FB)) u_divx (
			.clk(clk), .prod(px_s1[i]), .den(den_s1[i]), .quo(rx[i])
		);
		tfc_div #(.CB(CB), .FB(FB)) u_divy (
			.clk(clk), .prod(py_s1[i]), .den(den_s1[i]), .quo(ry[i])
		);
	end

	always_comb begin
		mnx = rx[0];
		mxx = rx[0];
		mny = ry[0];
		mxy = ry[0];
		for (int i = 1; i < 3; i++) begin
			if (rx[i] < mnx) mnx = rx[i];
			if (rx[i] > mxx) mxx = rx[i];
			if (ry[i] < mny) mny = ry[i];
			if (ry[i] > mxy) mxy = ry[i];
		end
		wm1 = (scr_w == '0) ? '0 : scr_w - 1'b1;
		hm1 = (scr_h == '0) ? '0 : scr_h - 1'b1;
		limx = {wm1, {FB{1'b0}}};
		limy = {hm1, {FB{1'b0}}};
		fullx = {scr_w, {FB{1'b0}}};
		fully = {scr_h, {FB{1'b0}}};
		if (mxx > limx) mxx = limx;
		if (mxy > limy) mxy = limy;
	end

	always_ff @(posedge clk) begin
		cls_q <= cls_d_q[QB-1];
		case (cls_d_q[QB-1])
			CLS_ACCEPT: begin
				mnx_q <= BOX_BITS'(mnx);
				mny_q <= BOX_BITS'(mny);
				mxx_q <= BOX_BITS'(mxx);
				mxy_q <= BOX_BITS'(mxy);
			end
			CLS_CLIP: begin
				mnx_q <= '0;
				mny_q <= '0;
				mxx_q <= BOX_BITS'(fullx);
				mxy_q <= BOX_BITS'(fully);
			end
			default: begin
				mnx_q <= '0;
				mny_q <= '0;
				mxx_q <= '0;
				mxy_q <= '0;
			end
		endcase
	end

	assign done = done_q;
	assign out_cls = cls_q;
	assign min_x = mnx_q;
	assign min_y = mny_q;
	assign max_x = mxx_q;
	assign max_y = mxy_q;

endmodule

/* rtl/triangle_frustum_cull_bbox.sv */
// Triangle frustum cull with screen bounding box.
// A triangle beat is taken at a rising edge where start is high and busy is
// low; it carries three clip-space vertices in signed fixed point.
// Screen width and height are written through cfg_we, cfg_index and cfg_data,
// other indexes being ignored; the user must do so only with no triangle in flight; the block does not enforce it.
// Each result appears for exactly one cycle with done high, giving the clip
// class and the box in unsigned fixed point. Results leave in arrival order.
// The results pass through the bit-per-stage restoring dividers, six of which
// run side by side.
// A new triangle may be started every cycle; busy stays low in normal use.
// Classification sits in a front stage and feeds a short queue; the back
// pipeline drains it every cycle, as the receiver cannot stall.
// Reset clears all valid state and loads width 320 and height 240.
module triangle_frustum_cull_bbox #(
	parameter int COORD_BITS = tfc_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS = tfc_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [tfc_pkg::REG_BITS-1:0]  cfg_data,
	input  logic signed [COORD_BITS-1:0]  v0_x,
	input  logic signed [COORD_BITS-1:0]  v0_y,
	input  logic signed [COORD_BITS-1:0]  v0_z,
	input  logic signed [COORD_BITS-1:0]  v0_w,
	input  logic signed [COORD_BITS-1:0]  v1_x,
	input  logic signed [COORD_BITS-1:0]  v1_y,
	input  logic signed [COORD_BITS-1:0]  v1_z,
	input  logic signed [COORD_BITS-1:0]  v1_w,
	input  logic signed [COORD_BITS-1:0]  v2_x,
	input  logic signed [COORD_BITS-1:0]  v2_y,
	input  logic signed [COORD_BITS-1:0]  v2_z,
	input  logic signed [COORD_BITS-1:0]  v2_w,
	output logic                          done,
	output logic [1:0]                    clip_class,
	output logic [tfc_pkg::BOX_BITS-1:0]  box_min_x,
	output logic [tfc_pkg::BOX_BITS-1:0]  box_min_y,
	output logic [tfc_pkg::BOX_BITS-1:0]  box_max_x,
	output logic [tfc_pkg::BOX_BITS-1:0]  box_max_y
);
	import tfc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = 2 + 9 * CB;

	logic [REG_BITS-1:0] width_q, height_q;
	front_ctl_t fctl;
	logic q_full, q_vld, f_vld_s1;
	clip_class_t f_cls_s1, b_cls, o_cls;
	logic [CB-1:0] f_nx_s1 [3];
	logic [CB-1:0] f_ny_s1 [3];
	logic [CB-1:0] f_dn_s1 [3];
	logic [CB-1:0] b_nx [3];
	logic [CB-1:0] b_ny [3];
	logic [CB-1:0] b_dn [3];
	logic signed [CB-1:0] vx [3];
	logic signed [CB-1:0] vy [3];
	logic signed [CB-1:0] vz [3];
	logic signed [CB-1:0] vw [3];
	logic [EW-1:0] q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign vx[0] = v0_x;
	assign vy[0] = v0_y;
	assign vz[0] = v0_z;
	assign vw[0] = v0_w;
	assign vx[1] = v1_x;
	assign vy[1] = v1_y;
	assign vz[1] = v1_z;
	assign vw[1] = v1_w;
	assign vx[2] = v2_x;
	assign vy[2] = v2_y;
	assign vz[2] = v2_z;
	assign vw[2] = v2_w;

	assign busy = f_vld_s1 && q_full;
	assign fctl.take = start && !busy;
	assign fctl.full = q_full;

	tfc_front #(.CB(CB)) u_front (
		.clk(clk), .arst_n(arst_n), .ctl(fctl),
		.vx(vx), .vy(vy), .vz(vz), .vw(vw),
		.vld_s1(f_vld_s1), .cls_s1(f_cls_s1),
		.numx_s1(f_nx_s1), .numy_s1(f_ny_s1), .den_s1(f_dn_s1)
	);

	assign q_din = {f_cls_s1, f_nx_s1[0], f_nx_s1[1], f_nx_s1[2],
		f_ny_s1[0], f_ny_s1[1], f_ny_s1[2], f_dn_s1[0], f_dn_s1[1], f_dn_s1[2]};

	tfc_fifo #(.DW(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_vld_s1), .din(q_din),
		.full(q_full), .vld(q_vld), .dout(q_dout)
	);

	assign b_cls = clip_class_t'(q_dout[EW-1:EW-2]);
	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign b_nx[i] = q_dout[(9 - i) * CB - 1 -: CB];
		assign b_ny[i] = q_dout[(6 - i) * CB - 1 -: CB];
		assign b_dn[i] = q_dout[(3 - i) * CB - 1 -: CB];
	end

	tfc_back #(.CB(CB), .FB(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .vld(q_vld), .cls(b_cls),
		.numx(b_nx), .numy(b_ny), .den(b_dn),
		.scr_w(width_q), .scr_h(height_q),
		.done(done), .out_cls(o_cls),
		.min_x(box_min_x), .min_y(box_min_y),
		.max_x(box_max_x), .max_y(box_max_y)
	);

	assign clip_class = o_cls;

endmodule
